FILE: rtl/sha1he_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// No dependencies; imported by every module of the engine.
package sha1he_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned WORDS  = 5;

	// Compression working variables a..e
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

endpackage

FILE: rtl/sha1he_round.sv
// One SHA-1 round: boolean function, round constant and five-operand add.
// Depends on sha1he_pkg; shared by all 80 rounds under the top-level sequencer.
module sha1he_round (
	input  sha1he_pkg::work_t cur,
	input  logic [31:0]       w,
	input  logic [6:0]        rnd,
	output sha1he_pkg::work_t nxt
);
	import sha1he_pkg::*;

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K0;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K1;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K3;
		end
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

FILE: rtl/sha1he_wsched.sv
// Block buffer and message schedule: a 16-word window that takes bytes
// big-endian and slides one expanded word per round. Depends on sha1he_pkg.
module sha1he_wsched (
	input  logic        clk,
	input  logic        shift_byte,
	input  logic [7:0]  byte_in,
	input  logic        shift_word,
	output logic [31:0] w_cur
);
	import sha1he_pkg::*;

	logic [511:0] blk_q;
	logic [31:0]  x;
	logic [31:0]  w_new;

	// word i of the window sits at blk_q[511-32*i -: 32]
	assign w_cur = blk_q[511:480];
	assign x     = blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32]
	             ^ blk_q[511-32*2 -: 32] ^ blk_q[511:480];
	assign w_new = {x[30:0], x[31]};

	always_ff @(posedge clk) begin
		if (shift_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (shift_word) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

endmodule

FILE: rtl/sha1_hash_engine_top.sv
// SHA-1 hash engine top level: sequencer, chaining values and stream ports.
// Depends on sha1he_pkg, sha1he_round and sha1he_wsched.
//
// Message bytes enter one per transaction (tuser = byte present, tlast = end
// of message). Every 64th byte starts a compression that runs all 80 rounds
// through the single round unit and then folds the result into the chaining
// values; the input is not ready meanwhile.
// At end of message the engine writes the padding and the 64-bit length
// into the block buffer one byte per cycle (with an extra compression when
// the tail does not fit), runs the final compression and then presents
// the digest as five 32-bit words, h0 first. A new message can start once
// the fifth digest word is taken.
module sha1_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] has_byte
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);
	import sha1he_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COMP = 5'b00010,
		ST_ADD  = 5'b00100,
		ST_PAD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [31:0] chain_q [WORDS];
	work_t       work_q;
	work_t       work_nxt;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [6:0]  round_q;
	logic [2:0]  oidx_q;
	logic        pad_q;
	logic        mark_q;
	logic        fin_q;
	logic        last_q;

	logic        push_en;
	logic [7:0]  push_byte;
	logic        blk_full;
	logic [7:0]  len_byte;
	logic [31:0] w_cur;

	sha1he_wsched u_wsched (
		.clk        (clk),
		.shift_byte (push_en),
		.byte_in    (push_byte),
		.shift_word (state_q == ST_COMP),
		.w_cur      (w_cur)
	);

	sha1he_round u_round (
		.cur (work_q),
		.w   (w_cur),
		.rnd (round_q),
		.nxt (work_nxt)
	);

	// length goes out big-endian at block bytes 56..63
	assign len_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];

	always_comb begin
		push_en   = 1'b0;
		push_byte = s_tdata;
		case (state_q)
			ST_IDLE: begin
				push_en   = s_tvalid & s_tuser[0];
				push_byte = s_tdata;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (!mark_q) begin
					push_byte = PAD_MARK;
				end else if (fin_q && pos_q >= 6'd56) begin
					push_byte = len_byte;
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en   = 1'b0;
				push_byte = s_tdata;
			end
		endcase
	end

	assign blk_full = push_en && (pos_q == 6'd63);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = chain_q[oidx_q];
	assign m_tuser  = oidx_q;
	assign m_tlast  = (oidx_q == 3'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
			chain_q[4] <= IV4;
			work_q     <= '0;
			len_q      <= '0;
			pos_q      <= '0;
			round_q    <= '0;
			oidx_q     <= '0;
			pad_q      <= 1'b0;
			mark_q     <= 1'b0;
			fin_q      <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			// a full block starts a compression from the current chain
			if (blk_full) begin
				work_q.a <= chain_q[0];
				work_q.b <= chain_q[1];
				work_q.c <= chain_q[2];
				work_q.d <= chain_q[3];
				work_q.e <= chain_q[4];
				round_q  <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser[0]) begin
							len_q <= len_q + 64'd8;
						end
						if (blk_full) begin
							pad_q   <= s_tlast;
							state_q <= ST_COMP;
						end else if (s_tlast) begin
							pad_q   <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					// length fits after the mark only if the mark lands before byte 56
					if (!mark_q && pos_q < 6'd56) begin
						fin_q <= 1'b1;
					end
					if (blk_full) begin
						if (fin_q) begin
							last_q <= 1'b1;
						end else begin
							fin_q <= 1'b1;
						end
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					work_q <= work_nxt;
					if (round_q == 7'(ROUNDS - 1)) begin
						round_q <= '0;
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					if (last_q) begin
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						if (oidx_q == 3'(WORDS - 1)) begin
							// restart for the next message
							oidx_q     <= '0;
							chain_q[0] <= IV0;
							chain_q[1] <= IV1;
							chain_q[2] <= IV2;
							chain_q[3] <= IV3;
							chain_q[4] <= IV4;
							len_q      <= '0;
							pos_q      <= '0;
							pad_q      <= 1'b0;
							mark_q     <= 1'b0;
							fin_q      <= 1'b0;
							last_q     <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/sha1_digest_checker.sv
// Scoreboard for the SHA-1 hash engine: rebuilds each digest from the accepted
// byte transactions and compares it word by word with the output stream.
// Depends on sha1he_pkg for the initial chaining values and round constants.
module sha1_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] has_byte
	input  logic        s_tlast,   // end_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] digest_word
	input  logic [2:0]  m_tuser,   // [2:0] word_index
	input  logic        m_tlast,   // last_word
	output int          fail_count,
	output int          words_pending
);

	localparam int BLOCK_BYTES = 64;
	localparam int LENGTH_POS  = 56;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_word_t;

	logic [31:0]  chain [sha1he_pkg::WORDS];
	logic [31:0]  msg_words [16];
	logic [63:0]  msg_bits;
	int           fill_pos;
	digest_word_t digest_due [$];
	int           errors = 0;

	function automatic void load_chain();
		chain[0] = sha1he_pkg::IV0;
		chain[1] = sha1he_pkg::IV1;
		chain[2] = sha1he_pkg::IV2;
		chain[3] = sha1he_pkg::IV3;
		chain[4] = sha1he_pkg::IV4;
	endfunction

	// 80 rounds; the schedule expands in place over the 16 buffered words
	function automatic void compress_block();
		logic [31:0] a, b, c, d, e, f, k, w, v, sum;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (int t = 0; t < sha1he_pkg::ROUNDS; t++) begin
			if (t >= 16) begin
				v = msg_words[(t + 13) % 16] ^ msg_words[(t + 8) % 16]
				  ^ msg_words[(t + 2) % 16] ^ msg_words[t % 16];
				msg_words[t % 16] = {v[30:0], v[31]};
			end
			w = msg_words[t % 16];
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = sha1he_pkg::K0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = sha1he_pkg::K1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1he_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1he_pkg::K3;
			end
			sum = {a[26:0], a[31:27]} + f + e + k + w;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
		chain[4] = chain[4] + e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] data);
		int idx;
		int sh;
		idx = fill_pos / 4;
		sh = (3 - fill_pos % 4) * 8;
		// clear a word on its first byte so nothing stale survives
		if (fill_pos % 4 == 0)
			msg_words[idx] = '0;
		msg_words[idx] = msg_words[idx] | ({24'd0, data} << sh);
		fill_pos++;
		if (fill_pos == BLOCK_BYTES) begin
			compress_block();
			fill_pos = 0;
		end
	endfunction

	function automatic void close_message();
		logic [63:0]  len;
		digest_word_t dw;
		len = msg_bits;
		absorb_byte(sha1he_pkg::PAD_MARK);
		while (fill_pos != LENGTH_POS)
			absorb_byte(8'h00);
		msg_words[14] = len[63:32];
		msg_words[15] = len[31:0];
		compress_block();
		for (int i = 0; i < sha1he_pkg::WORDS; i++) begin
			dw.value      = chain[i];
			dw.word_index = 3'(i);
			dw.last_word  = (i == sha1he_pkg::WORDS - 1);
			digest_due.push_back(dw);
		end
		load_chain();
		msg_bits = '0;
		fill_pos = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digest_word_t due;
		if (!arst_n) begin
			load_chain();
			for (int i = 0; i < 16; i++)
				msg_words[i] = '0;
			msg_bits = '0;
			fill_pos = 0;
			digest_due.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					msg_bits = msg_bits + 64'd8;
					absorb_byte(s_tdata);
				end
				if (s_tlast)
					close_message();
			end
			if (m_tvalid && m_tready) begin
				if (digest_due.size() == 0) begin
					$display("%0t: unexpected digest transaction: word %h index %0d last %b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					due = digest_due.pop_front();
					if (m_tdata !== due.value) begin
						$display("%0t: digest word expected %h got %h", $time, due.value, m_tdata);
						errors++;
					end
					if (m_tuser !== due.word_index) begin
						$display("%0t: word index expected %0d got %0d",
							$time, due.word_index, m_tuser);
						errors++;
					end
					if (m_tlast !== due.last_word) begin
						$display("%0t: last word expected %b got %b", $time, due.last_word, m_tlast);
						errors++;
					end
				end
			end
		end
		fail_count    <= errors;
		words_pending <= digest_due.size();
	end

endmodule

FILE: tb/tb_top.sv
// Top of the SHA-1 hash engine testbench: clock, reset, message stimulus and
// output back-pressure. Depends on sha1_hash_engine_top and sha1_digest_checker.
module tb_top;

	localparam int ITEMS_PER_PHASE = 118;
	localparam int HOLD_CYCLES     = 600;
	localparam int DRAIN_CYCLES    = 100;
	localparam int CYCLE_LIMIT     = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int words_pending;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_go        = 1'b0;
	int items_sent     = 0;
	int cycle_count    = 0;

	always #6 clk = ~clk;

	sha1_hash_engine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sha1_digest_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sha1_hash_engine_top verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off so the engine backs up
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input bit has_byte, input logic [7:0] data, input bit eom);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= has_byte;
		s_tdata  <= data;
		s_tlast  <= eom;
		// hold until the transaction is taken
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Mostly short messages; some land on the padding and block boundaries
	task automatic send_message();
		int len;
		int pick;
		bit end_on_byte;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			len = $urandom_range(0, 12);
		else if (pick < 8)
			len = $urandom_range(50, 70);
		else if (pick < 9)
			len = $urandom_range(110, 130);
		else
			len = $urandom_range(1, 40);
		end_on_byte = (len > 0) && $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_item(1'b0, 8'($urandom), 1'b0);
				items_sent++;
			end
			send_item(1'b1, 8'($urandom), end_on_byte && (i == len - 1));
			items_sent++;
		end
		if (!end_on_byte) begin
			send_item(1'b0, 8'($urandom), 1'b1);
			items_sent++;
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		s_tlast  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message
		send_item(1'b0, 8'hFF, 1'b1);
		// "abc", ending on a byte
		send_item(1'b1, 8'h61, 1'b0);
		send_item(1'b1, 8'h62, 1'b0);
		send_item(1'b1, 8'h63, 1'b1);
		// idle transaction carries a byte that must be dropped
		send_item(1'b0, 8'hA5, 1'b0);
		send_item(1'b1, 8'hFF, 1'b1);
		// extreme bytes around an idle, closed by an empty tail
		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b0, 8'h5A, 1'b0);
		send_item(1'b1, 8'hFF, 1'b0);
		send_item(1'b1, 8'h80, 1'b0);
		send_item(1'b0, 8'hC3, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 57;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 57;
					hold_go        = 1'b1;
				end
				default: begin
					send_idle_pct  = 21;
					recv_stall_pct = 21;
				end
			endcase
			while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
				send_message();
		end

		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		do
			@(posedge clk);
		while (words_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("sha1_hash_engine_top verification clean");
		else
			$display("sha1_hash_engine_top verification failed");
		$finish;
	end

endmodule
